FILE: rtl/core/csrd_pkg.sv
// Package for the CSR row densify block: shared types, codes and sizes.
// Used by csrd_front, csrd_back and csr_row_densify_top; depends on nothing.
package csrd_pkg;

	// Default sizes of the stores.
	localparam int P_MAX_ROWS     = 256;
	localparam int P_MAX_NONZEROS = 1024;
	localparam int P_MAX_COLS     = 64;

	// Depths of the command queue and of the result queue.
	localparam int CQ_DEPTH = 2;
	localparam int OQ_DEPTH = 4;

	// Field widths of the input and result words.
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 10;
	localparam int RSTART_W = 11;
	localparam int COL_W    = 6;
	localparam int VAL_W    = 32;
	localparam int RIDX_W   = 9;
	localparam int NROWS_W  = 9;
	localparam int NCOLS_W  = 7;

	// Operation codes of an input word.
	localparam logic [OP_W-1:0] OP_WR_PTR = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_NZ  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	// Register indexes, taken from paddr[2].
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	// Command kinds after classification in the front part.
	typedef enum logic [1:0] {
		CMD_WR_PTR,
		CMD_WR_NZ,
		CMD_QUERY,
		CMD_ERROR
	} cmd_kind_t;

	// One classified command; addr holds the resolved row for a query.
	typedef struct packed {
		cmd_kind_t             kind;
		logic [ADDR_W-1:0]     addr;
		logic [RSTART_W-1:0]   row_start;
		logic [COL_W-1:0]      column;
		logic [VAL_W-1:0]      value;
		logic [NCOLS_W-1:0]    ncols;
		logic                  fin;
	} cmd_t;

	// Configuration registers as seen by the front part.
	typedef struct packed {
		logic [NROWS_W-1:0] num_rows;
		logic [NCOLS_W-1:0] num_cols;
	} cfg_t;

	// One result word.
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [VAL_W-1:0] value;
		logic             last;
		logic             bend;
		logic             err;
	} res_t;

	// A result in flight while its value is read from the row buffer.
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic             last;
		logic             bend;
		logic             err;
		logic             use_ram;
	} emit_t;

	// States of the back part.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PTR_A,
		BK_PTR_B,
		BK_WALK,
		BK_EMIT
	} bk_state_t;

endpackage

FILE: rtl/core/csrd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used by csrd_back for every store of the block.
module csrd_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/csrd_front.sv
// Front part: accepts input words, classifies them and queues commands.
// Depends on csrd_pkg; feeds csrd_back through a short command queue.
module csrd_front #(
	parameter int MAX_ROWS     = csrd_pkg::P_MAX_ROWS,
	parameter int MAX_NONZEROS = csrd_pkg::P_MAX_NONZEROS,
	parameter int MAX_COLS     = csrd_pkg::P_MAX_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csrd_pkg::cfg_t                cfg,
	input  logic                          push,
	output logic                          full,
	input  logic [csrd_pkg::OP_W-1:0]     op,
	input  logic [csrd_pkg::ADDR_W-1:0]   addr,
	input  logic [csrd_pkg::RSTART_W-1:0] row_start,
	input  logic [csrd_pkg::COL_W-1:0]    column,
	input  logic [csrd_pkg::VAL_W-1:0]    value_bits,
	input  logic [csrd_pkg::RIDX_W-1:0]   row_index,
	input  logic                          final_row,
	output logic                          cmd_valid,
	output csrd_pkg::cmd_t                cmd,
	input  logic                          cmd_pop
);

	import csrd_pkg::*;

	localparam int PW  = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CNW = $clog2(CQ_DEPTH + 1);

	logic [NROWS_W-1:0] nrows;
	logic [NCOLS_W-1:0] ncols;
	logic [10:0]        ix_ext;
	logic [10:0]        ix_res;
	logic               in_range;
	logic               keep;
	cmd_t               cmd_new;
	logic               accept;

	cmd_t               q_mem [CQ_DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CNW-1:0]     count_q;

	// Clamp row and column counts to the store sizes; zero columns give one.
	always_comb begin
		if (32'(cfg.num_rows) > MAX_ROWS) begin
			nrows = NROWS_W'(MAX_ROWS);
		end else begin
			nrows = cfg.num_rows;
		end
		if (cfg.num_cols == '0) begin
			ncols = NCOLS_W'(1);
		end else if (32'(cfg.num_cols) > MAX_COLS) begin
			ncols = NCOLS_W'(MAX_COLS);
		end else begin
			ncols = cfg.num_cols;
		end
	end

	// Resolve a negative row index against the row count and range check it.
	always_comb begin
		ix_ext = {{2{row_index[RIDX_W-1]}}, row_index};
		if (row_index[RIDX_W-1]) begin
			ix_res = ix_ext + {2'b00, nrows};
		end else begin
			ix_res = ix_ext;
		end
		in_range = !ix_res[10] && (ix_res < {2'b00, nrows});
	end

	// Classify the word; dropped words are accepted but never queued.
	always_comb begin
		cmd_new.kind      = CMD_WR_PTR;
		cmd_new.addr      = addr;
		cmd_new.row_start = row_start;
		cmd_new.column    = column;
		cmd_new.value     = value_bits;
		cmd_new.ncols     = ncols;
		cmd_new.fin       = final_row;
		keep              = 1'b0;
		unique case (op)
			OP_WR_PTR: begin
				cmd_new.kind = CMD_WR_PTR;
				keep         = (32'(addr) <= MAX_ROWS);
			end
			OP_WR_NZ: begin
				cmd_new.kind = CMD_WR_NZ;
				keep         = (32'(addr) < MAX_NONZEROS);
			end
			OP_QUERY: begin
				cmd_new.kind = in_range ? CMD_QUERY : CMD_ERROR;
				cmd_new.addr = ix_res[ADDR_W-1:0];
				keep         = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full      = (count_q == CNW'(CQ_DEPTH));
	assign accept    = push && !full;
	assign cmd_valid = (count_q != '0);
	assign cmd       = q_mem[rd_ptr_q];

	// Command queue storage.
	always_ff @(posedge clk) begin
		if (accept && keep) begin
			q_mem[wr_ptr_q] <= cmd_new;
		end
	end

	// Command queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if ((accept && keep) && !cmd_pop) begin
				count_q <= count_q + CNW'(1);
			end else if (!(accept && keep) && cmd_pop) begin
				count_q <= count_q - CNW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/csrd_back.sv
// Back part: executes queued commands on the stores and emits dense rows.
// Depends on csrd_pkg and csrd_ram; drives the result queue of the block.
module csrd_back #(
	parameter int MAX_ROWS     = csrd_pkg::P_MAX_ROWS,
	parameter int MAX_NONZEROS = csrd_pkg::P_MAX_NONZEROS,
	parameter int MAX_COLS     = csrd_pkg::P_MAX_COLS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  csrd_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output csrd_pkg::res_t res
);

	import csrd_pkg::*;

	localparam int RP_AW = $clog2(MAX_ROWS + 1);
	localparam int NZ_AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
	localparam int CAW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int JW    = (NZ_AW + 1 > RSTART_W) ? NZ_AW + 1 : RSTART_W;
	localparam int NZ_W  = COL_W + VAL_W;
	localparam int OPW   = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
	localparam int OCW   = $clog2(OQ_DEPTH + 1);

	bk_state_t             state_q, state_d;

	// Query context.
	logic [ADDR_W-1:0]     ix_q;
	logic [NCOLS_W-1:0]    ncols_q;
	logic                  fin_q;
	logic [JW-1:0]         j_q;
	logic [JW-1:0]         end_q;
	logic [JW-1:0]         end_raw;
	logic [NCOLS_W-1:0]    c_q;
	logic [MAX_COLS-1:0]   valid_q;
	logic                  nz_s1;

	// Store ports.
	logic                  rp_we, rp_re;
	logic [RP_AW-1:0]      rp_raddr;
	logic [RSTART_W-1:0]   rp_rdata;
	logic                  nz_we, nz_re;
	logic [NZ_W-1:0]       nz_rdata;
	logic [COL_W-1:0]      nz_col;
	logic                  dn_we, dn_re;
	logic [VAL_W-1:0]      dn_rdata;

	// Sequencer strobes.
	logic                  ctx_load, clear_valid, j_load, end_load, j_inc;
	logic                  c_clr, c_inc, s1_load, col_last;
	emit_t                 s1_d;
	emit_t                 s1_s1;
	logic                  s1_valid_s1;

	// Result queue.
	res_t                  oq_mem [OQ_DEPTH];
	logic [OPW-1:0]        oq_wr_q, oq_rd_q;
	logic [OCW-1:0]        oq_cnt_q;
	logic [OCW:0]          occ;
	logic                  credit;
	logic                  oq_pop;
	res_t                  res_new;

	// Row pointer table, nonzero store and dense row buffer.
	csrd_ram #(.W(RSTART_W), .DEPTH(MAX_ROWS + 1), .AW(RP_AW)) u_rp_ram (
		.clk   (clk),
		.we    (rp_we),
		.waddr (RP_AW'(cmd.addr)),
		.wdata (cmd.row_start),
		.re    (rp_re),
		.raddr (rp_raddr),
		.rdata (rp_rdata)
	);

	csrd_ram #(.W(NZ_W), .DEPTH(MAX_NONZEROS), .AW(NZ_AW)) u_nz_ram (
		.clk   (clk),
		.we    (nz_we),
		.waddr (NZ_AW'(cmd.addr)),
		.wdata ({cmd.column, cmd.value}),
		.re    (nz_re),
		.raddr (NZ_AW'(j_q)),
		.rdata (nz_rdata)
	);

	assign nz_col = nz_rdata[NZ_W-1:VAL_W];
	assign dn_we  = nz_s1 && ({1'b0, nz_col} < ncols_q);

	csrd_ram #(.W(VAL_W), .DEPTH(MAX_COLS), .AW(CAW)) u_dn_ram (
		.clk   (clk),
		.we    (dn_we),
		.waddr (CAW'(nz_col)),
		.wdata (nz_rdata[VAL_W-1:0]),
		.re    (dn_re),
		.raddr (CAW'(c_q)),
		.rdata (dn_rdata)
	);

	// Room in the result queue, counting the word in flight.
	assign occ    = {1'b0, oq_cnt_q} + {{OCW{1'b0}}, s1_valid_s1};
	assign credit = (occ < (OCW + 1)'(OQ_DEPTH));

	assign col_last = ((c_q + NCOLS_W'(1)) == ncols_q);
	assign end_raw  = JW'(rp_rdata);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer strobes.
	always_comb begin
		state_d     = state_q;
		cmd_pop     = 1'b0;
		rp_we       = 1'b0;
		rp_re       = 1'b0;
		rp_raddr    = RP_AW'(cmd.addr);
		nz_we       = 1'b0;
		nz_re       = 1'b0;
		dn_re       = 1'b0;
		ctx_load    = 1'b0;
		clear_valid = 1'b0;
		j_load      = 1'b0;
		end_load    = 1'b0;
		j_inc       = 1'b0;
		c_clr       = 1'b0;
		c_inc       = 1'b0;
		s1_load     = 1'b0;
		s1_d        = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_WR_PTR: begin
							cmd_pop = 1'b1;
							rp_we   = 1'b1;
						end
						CMD_WR_NZ: begin
							cmd_pop = 1'b1;
							nz_we   = 1'b1;
						end
						CMD_QUERY: begin
							cmd_pop     = 1'b1;
							rp_re       = 1'b1;
							ctx_load    = 1'b1;
							clear_valid = 1'b1;
							state_d     = BK_PTR_A;
						end
						CMD_ERROR: begin
							if (credit) begin
								cmd_pop      = 1'b1;
								s1_load      = 1'b1;
								s1_d.last    = 1'b1;
								s1_d.bend    = cmd.fin;
								s1_d.err     = 1'b1;
							end
						end
						default: begin
							cmd_pop = 1'b0;
						end
					endcase
				end
			end
			BK_PTR_A: begin
				j_load   = 1'b1;
				rp_re    = 1'b1;
				rp_raddr = RP_AW'({1'b0, ix_q} + 11'd1);
				state_d  = BK_PTR_B;
			end
			BK_PTR_B: begin
				end_load = 1'b1;
				state_d  = BK_WALK;
			end
			BK_WALK: begin
				if (j_q < end_q) begin
					nz_re = 1'b1;
					j_inc = 1'b1;
				end else if (!nz_s1) begin
					c_clr   = 1'b1;
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (credit) begin
					dn_re        = 1'b1;
					c_inc        = 1'b1;
					s1_load      = 1'b1;
					s1_d.column  = c_q[COL_W-1:0];
					s1_d.last    = col_last;
					s1_d.bend    = col_last && fin_q;
					s1_d.use_ram = valid_q[CAW'(c_q)];
					if (col_last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Query context, walk pointer and emit counter.
	always_ff @(posedge clk) begin
		if (ctx_load) begin
			ix_q    <= cmd.addr;
			ncols_q <= cmd.ncols;
			fin_q   <= cmd.fin;
		end
		if (j_load) begin
			j_q <= JW'(rp_rdata);
		end else if (j_inc) begin
			j_q <= j_q + JW'(1);
		end
		if (end_load) begin
			end_q <= (end_raw > JW'(MAX_NONZEROS)) ? JW'(MAX_NONZEROS) : end_raw;
		end
		if (c_clr) begin
			c_q <= '0;
		end else if (c_inc) begin
			c_q <= c_q + NCOLS_W'(1);
		end
		if (s1_load) begin
			s1_s1 <= s1_d;
		end
	end

	// Valid bits of the row buffer and in-flight flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			nz_s1       <= 1'b0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (clear_valid) begin
				valid_q <= '0;
			end else if (dn_we) begin
				valid_q[CAW'(nz_col)] <= 1'b1;
			end
			nz_s1       <= nz_re;
			s1_valid_s1 <= s1_load;
		end
	end

	// Result word built from the row buffer read.
	always_comb begin
		res_new.column = s1_s1.column;
		res_new.value  = s1_s1.use_ram ? dn_rdata : '0;
		res_new.last   = s1_s1.last;
		res_new.bend   = s1_s1.bend;
		res_new.err    = s1_s1.err;
	end

	assign empty  = (oq_cnt_q == '0);
	assign oq_pop = pop && !empty;
	assign res    = oq_mem[oq_rd_q];

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			oq_mem[oq_wr_q] <= res_new;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (s1_valid_s1) begin
				oq_wr_q <= (oq_wr_q == OPW'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + OPW'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == OPW'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + OPW'(1);
			end
			if (s1_valid_s1 && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + OCW'(1);
			end else if (!s1_valid_s1 && oq_pop) begin
				oq_cnt_q <= oq_cnt_q - OCW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/csr_row_densify_top.sv
// Top level of the CSR row densify block: configuration registers and wiring.
// Depends on csrd_pkg, csrd_front, csrd_back and csrd_ram.
//
// Write words (row pointer or nonzero entry) are handled in the back part
// and give no result. A query reads the two row pointers from the row
// pointer RAM, then reads each stored nonzero of the row into the row
// buffer, waits for the last read to land and closes the walk, then emits
// the dense row of num_cols words through the row buffer RAM, one word per
// cycle while the result side keeps popping. A bad row index gives a single
// error word. A two-entry command queue lets the input side keep pushing
// while a query is being emitted, and a four-entry result queue decouples
// the result side. Stores are not cleared at reset; entries read before
// they are written return unspecified data.
module csr_row_densify_top #(
	parameter int MAX_ROWS     = csrd_pkg::P_MAX_ROWS,
	parameter int MAX_NONZEROS = csrd_pkg::P_MAX_NONZEROS,
	parameter int MAX_COLS     = csrd_pkg::P_MAX_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// Input words.
	input  logic                          push,
	output logic                          full,
	input  logic [csrd_pkg::OP_W-1:0]     op,
	input  logic [csrd_pkg::ADDR_W-1:0]   addr,
	input  logic [csrd_pkg::RSTART_W-1:0] row_start,
	input  logic [csrd_pkg::COL_W-1:0]    column,
	input  logic [csrd_pkg::VAL_W-1:0]    value_bits,
	input  logic [csrd_pkg::RIDX_W-1:0]   row_index,
	input  logic                          final_row,
	// Result words.
	output logic                          empty,
	input  logic                          pop,
	output logic [csrd_pkg::COL_W-1:0]    out_column,
	output logic [csrd_pkg::VAL_W-1:0]    out_value,
	output logic                          row_last,
	output logic                          batch_end,
	output logic                          index_error
);

	import csrd_pkg::*;

	cfg_t cfg_q;
	logic cfg_wr;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	res_t res;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_rows <= '0;
			cfg_q.num_cols <= NCOLS_W'(64);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_NUM_ROWS: cfg_q.num_rows <= pwdata[NROWS_W-1:0];
				REG_NUM_COLS: cfg_q.num_cols <= pwdata[NCOLS_W-1:0];
				default: cfg_q.num_rows <= cfg_q.num_rows;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (paddr[2])
			REG_NUM_ROWS: prdata = {{(32 - NROWS_W){1'b0}}, cfg_q.num_rows};
			REG_NUM_COLS: prdata = {{(32 - NCOLS_W){1'b0}}, cfg_q.num_cols};
			default:      prdata = '0;
		endcase
	end

	csrd_front #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_NONZEROS (MAX_NONZEROS),
		.MAX_COLS     (MAX_COLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.op         (op),
		.addr       (addr),
		.row_start  (row_start),
		.column     (column),
		.value_bits (value_bits),
		.row_index  (row_index),
		.final_row  (final_row),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	csrd_back #(
		.MAX_ROWS     (MAX_ROWS),
		.MAX_NONZEROS (MAX_NONZEROS),
		.MAX_COLS     (MAX_COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign out_column  = res.column;
	assign out_value   = res.value;
	assign row_last    = res.last;
	assign batch_end   = res.bend;
	assign index_error = res.err;

	// The back part only takes a command that the queue holds.
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command taken from an empty command queue");

	// An error word is a lone, zero word that closes its row.
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && index_error) |-> (row_last && out_column == '0 && out_value == '0))
		else $error("malformed error word");

	// The batch end mark only rides on the last word of a row.
	a_batch_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && batch_end) |-> row_last)
		else $error("batch end on a word that is not the last of its row");

endmodule

FILE: tb/sv/tb_csr_row_densify_top.sv
// Self-checking testbench for csr_row_densify_top: loads CSR tables, queries rows
// and checks every dense result word against an in-bench row densifier.
// Depends on csrd_pkg and csr_row_densify_top.
module tb_csr_row_densify_top;
	import csrd_pkg::*;

	// Op code 3 has no meaning in the block and must be ignored.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	// Cycles of quiet after the last expected word before a register write.
	localparam int QUIET_CYCLES = 100;
	// Longest row span that the stimulus fills with nonzero entries.
	localparam int MAX_SPAN = 24;

	// One input word as pushed into the block.
	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [ADDR_W-1:0]   addr;
		logic [RSTART_W-1:0] row_start;
		logic [COL_W-1:0]    column;
		logic [VAL_W-1:0]    value_bits;
		logic [RIDX_W-1:0]   row_index;
		logic                final_row;
	} csr_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                push = 1'b0;
	logic                full;
	logic [OP_W-1:0]     op = '0;
	logic [ADDR_W-1:0]   addr = '0;
	logic [RSTART_W-1:0] row_start = '0;
	logic [COL_W-1:0]    column = '0;
	logic [VAL_W-1:0]    value_bits = '0;
	logic [RIDX_W-1:0]   row_index = '0;
	logic                final_row = 1'b0;
	logic                empty;
	logic                pop = 1'b0;
	logic [COL_W-1:0]    out_column;
	logic [VAL_W-1:0]    out_value;
	logic                row_last;
	logic                batch_end;
	logic                index_error;

	csr_row_densify_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.push        (push),
		.full        (full),
		.op          (op),
		.addr        (addr),
		.row_start   (row_start),
		.column      (column),
		.value_bits  (value_bits),
		.row_index   (row_index),
		.final_row   (final_row),
		.empty       (empty),
		.pop         (pop),
		.out_column  (out_column),
		.out_value   (out_value),
		.row_last    (row_last),
		.batch_end   (batch_end),
		.index_error (index_error)
	);

	always #10 clk = ~clk;

	// Words waiting to be pushed and dense words waiting to come out.
	csr_word_t pending_words [$];
	res_t      dense_expected [$];

	// Densifier state: register copies and the three tables.
	logic [NROWS_W-1:0]  cfg_rows = '0;
	logic [NCOLS_W-1:0]  cfg_cols = 7'd64;
	logic [RSTART_W-1:0] ptr_table [0:P_MAX_ROWS];
	logic [COL_W-1:0]    nz_column [0:P_MAX_NONZEROS-1];
	logic [VAL_W-1:0]    nz_value  [0:P_MAX_NONZEROS-1];

	// Layout as planned by the stimulus, so that no query reads an unwritten entry.
	int plan_ptr     [0:P_MAX_ROWS];
	bit plan_ptr_set [0:P_MAX_ROWS];
	bit plan_nz_set  [0:P_MAX_NONZEROS-1];

	int        fail_count = 0;
	int        words_planned = 0;
	int        queries_seen = 0;
	int        words_checked = 0;
	int        settings_used = 0;
	bit        idle_on = 1'b1;
	int        in_gap = 0;
	int        out_gap = 0;
	csr_word_t sent_word;
	res_t      want;

	// Row and column counts as the block uses them.
	function automatic int used_rows();
		return (cfg_rows > P_MAX_ROWS) ? P_MAX_ROWS : int'(cfg_rows);
	endfunction

	function automatic int used_cols();
		if (cfg_cols == 0) return 1;
		if (cfg_cols > P_MAX_COLS) return P_MAX_COLS;
		return int'(cfg_cols);
	endfunction

	// Apply one accepted word and queue the dense words it must produce.
	task automatic densify_predict(input csr_word_t w);
		int          nrows;
		int          ncols;
		int          ix;
		int          j;
		int          stop;
		logic [31:0] row_buf [0:P_MAX_COLS-1];
		res_t        r;
		case (w.op)
			OP_WR_PTR: begin
				if (w.addr <= P_MAX_ROWS) ptr_table[w.addr] = w.row_start;
			end
			OP_WR_NZ: begin
				if (w.addr < P_MAX_NONZEROS) begin
					nz_column[w.addr] = w.column;
					nz_value[w.addr] = w.value_bits;
				end
			end
			OP_QUERY: begin
				queries_seen++;
				nrows = used_rows();
				ncols = used_cols();
				ix = int'($signed(w.row_index));
				if (ix < 0) ix += nrows;
				if (ix < 0 || ix >= nrows) begin
					r.column = '0;
					r.value = '0;
					r.last = 1'b1;
					r.bend = w.final_row;
					r.err = 1'b1;
					dense_expected.insert(dense_expected.size(), r);
				end else begin
					for (j = 0; j < P_MAX_COLS; j++) row_buf[j] = '0;
					stop = int'(ptr_table[ix + 1]);
					if (stop > P_MAX_NONZEROS) stop = P_MAX_NONZEROS;
					// Later entries overwrite earlier ones in the same column.
					for (j = int'(ptr_table[ix]); j < stop; j++) begin
						if (nz_column[j] < ncols) row_buf[nz_column[j]] = nz_value[j];
					end
					for (j = 0; j < ncols; j++) begin
						r.column = COL_W'(j);
						r.value = row_buf[j];
						r.last = (j == ncols - 1);
						r.bend = r.last & w.final_row;
						r.err = 1'b0;
						dense_expected.insert(dense_expected.size(), r);
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// A word with every field random; callers then set the fields that matter.
	function automatic csr_word_t random_word();
		csr_word_t w;
		w.op = OP_W'($urandom_range(0, 3));
		w.addr = ADDR_W'($urandom);
		w.row_start = RSTART_W'($urandom_range(0, P_MAX_NONZEROS));
		w.column = COL_W'($urandom);
		w.value_bits = $urandom;
		w.row_index = RIDX_W'($urandom);
		w.final_row = 1'($urandom);
		return w;
	endfunction

	// Mostly columns inside the row, sometimes wide ones that must be skipped.
	function automatic int pick_column();
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, P_MAX_COLS - 1);
		return $urandom_range(0, used_cols() - 1);
	endfunction

	task automatic add_word(input csr_word_t w);
		pending_words.insert(pending_words.size(), w);
		if (w.op == OP_WR_PTR && w.addr <= P_MAX_ROWS) begin
			plan_ptr[w.addr] = int'(w.row_start);
			plan_ptr_set[w.addr] = 1'b1;
		end
		if (w.op == OP_WR_NZ) begin
			plan_nz_set[w.addr] = 1'b1;
		end
		words_planned++;
	endtask

	task automatic put_ptr(input int slot, input int start);
		csr_word_t w;
		w = random_word();
		w.op = OP_WR_PTR;
		w.addr = ADDR_W'(slot);
		w.row_start = RSTART_W'(start);
		add_word(w);
	endtask

	task automatic put_nz(input int slot, input int col, input logic [31:0] val);
		csr_word_t w;
		w = random_word();
		w.op = OP_WR_NZ;
		w.addr = ADDR_W'(slot);
		w.column = COL_W'(col);
		w.value_bits = val;
		add_word(w);
	endtask

	// Queue a row query; for an in-range row, first write whatever it would read.
	task automatic add_query(input int ix_raw, input bit fin);
		int        ix;
		int        s;
		int        e;
		int        j;
		csr_word_t w;
		ix = ix_raw;
		if (ix < 0) ix += used_rows();
		if (ix >= 0 && ix < used_rows()) begin
			if (!plan_ptr_set[ix]) begin
				if (plan_ptr_set[ix + 1]) s = plan_ptr[ix + 1] - int'($urandom_range(0, 8));
				else s = $urandom_range(0, P_MAX_NONZEROS - 8);
				if (s < 0) s = 0;
				put_ptr(ix, s);
			end
			if (!plan_ptr_set[ix + 1] || plan_ptr[ix + 1] - plan_ptr[ix] > MAX_SPAN) begin
				// Now and then the end lands before the start.
				if ($urandom_range(0, 9) == 0 && plan_ptr[ix] > 0) e = plan_ptr[ix] - 1;
				else e = plan_ptr[ix] + int'($urandom_range(0, 10));
				if (e > P_MAX_NONZEROS) e = P_MAX_NONZEROS;
				put_ptr(ix + 1, e);
			end
			e = (plan_ptr[ix + 1] > P_MAX_NONZEROS) ? P_MAX_NONZEROS : plan_ptr[ix + 1];
			for (j = plan_ptr[ix]; j < e; j++) begin
				if (!plan_nz_set[j]) put_nz(j, pick_column(), $urandom);
			end
		end
		w = random_word();
		w.op = OP_QUERY;
		w.row_index = RIDX_W'(ix_raw);
		w.final_row = fin;
		add_word(w);
	endtask

	// Random traffic: mostly valid row queries, with table rewrites and noise.
	task automatic random_traffic(input int n_words);
		int        first;
		int        pick;
		int        nrows;
		int        ix;
		int        slot;
		int        v;
		csr_word_t w;
		first = words_planned;
		while (words_planned - first < n_words) begin
			pick = $urandom_range(0, 99);
			nrows = used_rows();
			if (pick < 55 && nrows > 0) begin
				ix = $urandom_range(0, nrows - 1);
				if ($urandom_range(0, 2) == 0) ix -= nrows;
				add_query(ix, 1'($urandom_range(0, 1)));
			end else if (pick < 65) begin
				add_query(int'($urandom_range(0, 511)) - 256, 1'($urandom_range(0, 1)));
			end else if (pick < 80) begin
				put_nz($urandom_range(0, P_MAX_NONZEROS - 1), pick_column(), $urandom);
			end else if (pick < 90) begin
				slot = $urandom_range(0, P_MAX_ROWS);
				if (slot > 0 && plan_ptr_set[slot - 1])
					v = plan_ptr[slot - 1] + int'($urandom_range(0, 12));
				else
					v = $urandom_range(0, P_MAX_NONZEROS);
				if (v > P_MAX_NONZEROS) v = P_MAX_NONZEROS;
				put_ptr(slot, v);
			end else if (pick < 95) begin
				// Row pointer slot past the table: ignored.
				put_ptr($urandom_range(P_MAX_ROWS + 1, 1023),
					$urandom_range(0, P_MAX_NONZEROS));
			end else begin
				w = random_word();
				w.op = OP_UNUSED;
				add_word(w);
			end
		end
	endtask

	// Wait until every word is pushed and every dense word has come out.
	task automatic wait_idle();
		while (pending_words.size() != 0 || push || dense_expected.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Register write followed by a read back of the same register.
	task automatic csr_write(input logic idx, input logic [31:0] val);
		logic [31:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_NUM_ROWS) begin
			cfg_rows = val[NROWS_W-1:0];
			if (readback[NROWS_W-1:0] !== cfg_rows) begin
				$display("%0t: num_rows read back mismatch, expected %h, actual %h",
					$time, cfg_rows, readback[NROWS_W-1:0]);
				fail_count++;
			end
		end else begin
			cfg_cols = val[NCOLS_W-1:0];
			if (readback[NCOLS_W-1:0] !== cfg_cols) begin
				$display("%0t: num_cols read back mismatch, expected %h, actual %h",
					$time, cfg_cols, readback[NCOLS_W-1:0]);
				fail_count++;
			end
		end
	endtask

	task automatic run_setting(input int rows, input int cols, input int n_words, input bit idle);
		wait_idle();
		csr_write(REG_NUM_ROWS, rows);
		csr_write(REG_NUM_COLS, cols);
		settings_used++;
		idle_on = idle;
		random_traffic(n_words);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// Input driver: pushes the oldest pending word, with random bursts of idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				sent_word = pending_words.pop_front();
				densify_predict(sent_word);
			end
			if (push && full) begin
				// Hold the word until the block takes it.
			end else if (in_gap != 0) begin
				in_gap--;
				push <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				in_gap = $urandom_range(0, 15);
				push <= 1'b0;
			end else if (pending_words.size() != 0) begin
				op <= pending_words[0].op;
				addr <= pending_words[0].addr;
				row_start <= pending_words[0].row_start;
				column <= pending_words[0].column;
				value_bits <= pending_words[0].value_bits;
				row_index <= pending_words[0].row_index;
				final_row <= pending_words[0].final_row;
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Result monitor: pops with random stalls and checks each word in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (dense_expected.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %0d %h %b %b %b",
						$time, out_column, out_value, row_last, batch_end, index_error);
					fail_count++;
				end else begin
					want = dense_expected.pop_front();
					check_field("out_column", 32'(want.column), 32'(out_column));
					check_field("out_value", want.value, out_value);
					check_field("row_last", 32'(want.last), 32'(row_last));
					check_field("batch_end", 32'(want.bend), 32'(batch_end));
					check_field("index_error", 32'(want.err), 32'(index_error));
					words_checked++;
				end
			end
			if (out_gap != 0) begin
				out_gap--;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_gap = $urandom_range(0, 15);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Main sequence: reset, directed rows, then random traffic over several settings.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset row count of zero, every query is an index error.
		add_query(0, 1'b1);
		wait_idle();
		csr_write(REG_NUM_ROWS, P_MAX_ROWS);
		csr_write(REG_NUM_COLS, P_MAX_COLS);
		settings_used++;

		// Row 0: extreme columns and values, and a duplicate column where the later wins.
		put_ptr(0, 0);
		put_ptr(1, 4);
		put_nz(0, 0, 32'hFFFF_FFFF);
		put_nz(1, P_MAX_COLS - 1, 32'h0000_0001);
		put_nz(2, 5, 32'hA5A5_A5A5);
		put_nz(3, 5, 32'h5A5A_5A5A);
		add_query(0, 1'b1);
		add_query(-P_MAX_ROWS, 1'b0);
		// Last row, ending at the top of the nonzero store.
		put_ptr(P_MAX_ROWS - 1, P_MAX_NONZEROS - 1);
		put_ptr(P_MAX_ROWS, P_MAX_NONZEROS);
		put_nz(P_MAX_NONZEROS - 1, P_MAX_COLS - 1, 32'h8000_0000);
		add_query(-1, 1'b1);
		add_query(P_MAX_ROWS - 1, 1'b0);
		// Row 1 starts after its end, row 2 is empty: both come out all zero.
		put_ptr(2, 2);
		add_query(1, 1'b0);
		put_ptr(3, 2);
		add_query(2, 1'b1);
		// An unused op and a row pointer write past the table change nothing.
		sent_word = random_word();
		sent_word.op = OP_UNUSED;
		add_word(sent_word);
		put_ptr(1023, P_MAX_NONZEROS);
		add_query(0, 1'b0);

		run_setting(P_MAX_ROWS, P_MAX_COLS, 35, 1'b1);
		run_setting(12, 1, 25, 1'b1);
		run_setting(P_MAX_ROWS, 13, 35, 1'b1);
		run_setting(1, P_MAX_COLS, 20, 1'b1);
		run_setting(0, 40, 15, 1'b1);
		run_setting(200, 37, 35, 1'b1);
		run_setting(64, P_MAX_COLS, 35, 1'b0);
		wait_idle();

		$display("Run covered %0d queries and %0d dense result words checked in order,",
			queries_seen, words_checked);
		$display("over %0d register writes with row counts 0 to 256 and 1 to 64 columns.",
			settings_used * 2);
		if (fail_count == 0 && dense_expected.size() == 0) begin
			$display("tb_csr_row_densify_top passed");
		end else begin
			$display("tb_csr_row_densify_top failed");
		end
		$finish;
	end

	// Guard against a hang anywhere in the run.
	initial begin
		#60000000;
		$display("tb_csr_row_densify_top failed");
		$finish;
	end

endmodule
